FILE: rtl/core/u8sd_pkg.sv
// shared types, constants and decode functions for the utf-8 stream decoder
// no dependencies; used by u8sd_datapath, u8sd_ctrl and the top level
package u8sd_pkg;

  // width of the running text offset (valid range 8..64)
  localparam int OFFSET_WIDTH = 32;

  localparam logic [7:0]  CONT_MASK  = 8'hc0;
  localparam logic [7:0]  CONT_TAG   = 8'h80;
  localparam logic [20:0] SURR_LO    = 21'h00d800;
  localparam logic [20:0] SURR_HI    = 21'h00dfff;
  localparam logic [20:0] MAX_SCALAR = 21'h10ffff;
  localparam logic [20:0] MIN_LEN2   = 21'h000080;
  localparam logic [20:0] MIN_LEN3   = 21'h000800;
  localparam logic [20:0] MIN_LEN4   = 21'h010000;

  // controller to datapath
  typedef struct packed {
    logic load;  // take the accepted request into the byte buffer
    logic step;  // resolve the head of the buffer into the output register
  } u8sd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hold;  // head sequence still waits for bytes
    logic last;  // the unit now at the head is the final one of this request
  } u8sd_stat_t;

  typedef struct packed {
    logic        ok;
    logic [20:0] value;
  } u8sd_dec_t;

  // sequence length from the lead byte, 0 for a byte that cannot lead
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return (b & CONT_MASK) == CONT_TAG;
  endfunction

  // decode len bytes b0..b3 (len 1..4), all bytes present
  function automatic u8sd_dec_t decode_seq(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3,
                                           input logic [2:0] len);
    u8sd_dec_t  d;
    logic [20:0] v;
    d = '0;
    v = '0;
    unique case (len)
      3'd1: begin
        d.ok    = 1'b1;
        d.value = {13'd0, b0};
      end
      3'd2: begin
        v = {10'd0, b0[4:0], b1[5:0]};
        d.ok = is_cont(b1) && (v >= MIN_LEN2);
      end
      3'd3: begin
        v = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
        d.ok = is_cont(b1) && is_cont(b2) && (v >= MIN_LEN3) &&
               !((v >= SURR_LO) && (v <= SURR_HI));
      end
      3'd4: begin
        v = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        d.ok = is_cont(b1) && is_cont(b2) && is_cont(b3) &&
               (v >= MIN_LEN4) && (v <= MAX_SCALAR);
      end
      default: begin
        d.ok = 1'b0;
      end
    endcase
    if (len != 3'd1) begin
      d.value = d.ok ? v : 21'd0;
    end
    return d;
  endfunction

endpackage

FILE: rtl/core/u8sd_datapath.sv
// byte buffer, sequence decode, offset counter and output register
// depends on u8sd_pkg
module u8sd_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  u8sd_pkg::u8sd_cmd_t   cmd,
  input  logic [7:0]            in_byte,
  input  logic                  end_of_text,
  output u8sd_pkg::u8sd_stat_t  stat,
  output logic [20:0]           scalar_value,
  output logic                  unit_ok,
  output logic [2:0]            unit_bytes,
  output logic [31:0]           start_offset,
  output logic                  run_last,
  output logic                  text_last
);

  logic [7:0]                        buf_q [4];
  logic [2:0]                        count;
  logic                              text_end;
  logic [u8sd_pkg::OFFSET_WIDTH-1:0] offset;

  logic [2:0]          len;
  logic [2:0]          len_next;
  logic [2:0]          used;
  logic [2:0]          rem;
  logic                full;
  u8sd_pkg::u8sd_dec_t dec;
  logic                unit_good;

  always_comb begin
    len       = u8sd_pkg::lead_length(buf_q[0]);
    full      = (len != 3'd0) && (count >= len);
    dec       = u8sd_pkg::decode_seq(buf_q[0], buf_q[1], buf_q[2], buf_q[3], len);
    unit_good = full && dec.ok;
    used      = unit_good ? len : 3'd1;
    rem       = count - used;
    len_next  = u8sd_pkg::lead_length(buf_q[used[1:0]]);
    stat.hold = (len != 3'd0) && (count < len) && !text_end;
    stat.last = (rem == 3'd0) ||
                (!text_end && (len_next != 3'd0) && (rem < len_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      offset   <= '0;
      text_end <= 1'b0;
    end else if (cmd.load) begin
      count    <= count + 3'd1;
      text_end <= end_of_text;
    end else if (cmd.step) begin
      count <= rem;
      if (text_end && stat.last) begin
        offset <= '0;
      end else begin
        offset <= offset + {{(u8sd_pkg::OFFSET_WIDTH-3){1'b0}}, used};
      end
    end
  end

  // buffer bytes: appended on load, shifted down by the consumed bytes on step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      buf_q[count[1:0]] <= in_byte;
    end else if (cmd.step) begin
      for (int i = 0; i < 4; i++) begin
        if ((3'(i) + used) < 3'd4) begin
          buf_q[i] <= buf_q[2'(3'(i) + used)];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      scalar_value <= unit_good ? dec.value : 21'd0;
      unit_ok      <= unit_good;
      unit_bytes   <= used;
      start_offset <= 32'(offset);
      run_last     <= stat.last;
      text_last    <= stat.last && text_end;
    end
  end

endmodule

FILE: rtl/core/u8sd_ctrl.sv
// sequencing controller: accept a byte, resolve units, hand them out
// depends on u8sd_pkg
module u8sd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  u8sd_pkg::u8sd_stat_t  stat,
  output u8sd_pkg::u8sd_cmd_t   cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   last_unit;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.hold) begin
          state_next = ST_IDLE;
        end else begin
          cmd.step   = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = last_unit ? ST_IDLE : ST_SCAN;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      last_unit <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.step) begin
        last_unit <= stat.last;
      end
    end
  end

endmodule

FILE: rtl/core/utf8_stream_decoder_unit.sv
// utf-8 stream decoder: a byte is accepted, then each unit it completes is scanned and
// handed out in turn; a byte that completes nothing goes from the scan back to accept,
// and a byte yields up to 4 units; the accept/scan/emit sequencer takes no new byte until
// every unit of the earlier one has been handed out
// synchronous active-high reset empties the byte buffer and clears the text offset
// depends on u8sd_pkg, u8sd_ctrl and u8sd_datapath
module utf8_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  // byte request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_text,
  // unit request channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] scalar_value,
  output logic        unit_ok,
  output logic [2:0]  unit_bytes,
  output logic [31:0] start_offset,
  output logic        run_last,
  output logic        text_last
);

  // command and status between sequencer and datapath
  u8sd_pkg::u8sd_cmd_t  cmd;
  u8sd_pkg::u8sd_stat_t stat;

  // sequencer: idle takes a byte, scan resolves the head of the buffer,
  // emit holds the output register until the unit request is taken
  u8sd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: up to four buffered bytes, decode of the head sequence,
  // running offset and the registered unit fields
  // a rejected sequence consumes only its lead byte; the rest shift down and
  // are rescanned as fresh starts on the next scan
  u8sd_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_byte      (in_byte),
    .end_of_text  (end_of_text),
    .stat         (stat),
    .scalar_value (scalar_value),
    .unit_ok      (unit_ok),
    .unit_bytes   (unit_bytes),
    .start_offset (start_offset),
    .run_last     (run_last),
    .text_last    (text_last)
  );

endmodule

FILE: rtl/core/u8sd_checker.sv
// port-level checks for utf8_stream_decoder_unit, attached by bind
// depends on nothing but the top level's ports
module u8sd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [20:0] scalar_value,
  input logic        unit_ok,
  input logic [2:0]  unit_bytes,
  input logic        run_last,
  input logic        text_last
);

  // a stalled unit request holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(scalar_value) &&
                                $stable(unit_ok) && $stable(unit_bytes))
    else $error("unit request changed while stalled");

  // an invalid unit is a single byte with a zero value
  a_bad_unit: assert property (@(posedge clk) disable iff (rst)
    out_valid && !unit_ok |-> unit_bytes == 3'd1 && scalar_value == 21'd0)
    else $error("invalid unit carries data");

  // a valid unit is a unicode scalar value
  a_scalar: assert property (@(posedge clk) disable iff (rst)
    out_valid && unit_ok |-> scalar_value <= 21'h10ffff &&
      (scalar_value < 21'h00d800 || scalar_value > 21'h00dfff) &&
      unit_bytes >= 3'd1 && unit_bytes <= 3'd4)
    else $error("valid unit out of range");

  // the end of a text is also the end of a byte's run
  a_text_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_last |-> run_last)
    else $error("text_last without run_last");

  // no new byte is taken while a unit is still waiting
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("byte accepted while a unit is pending");

endmodule

bind utf8_stream_decoder_unit u8sd_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .scalar_value (scalar_value),
  .unit_ok      (unit_ok),
  .unit_bytes   (unit_bytes),
  .run_last     (run_last),
  .text_last    (text_last)
);

FILE: test/utf8_stream_decoder_unit_checker.sv
// unit checker for the utf-8 stream decoder: predicts units from accepted byte requests
// and compares every unit request field by field; depends on u8sd_pkg
module utf8_stream_decoder_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_text,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [20:0] scalar_value,
  input  logic        unit_ok,
  input  logic [2:0]  unit_bytes,
  input  logic [31:0] start_offset,
  input  logic        run_last,
  input  logic        text_last,
  output int          mismatches,
  output int          units_waiting,
  output int          units_checked,
  output int          units_invalid
);

  // width of the running text position
  localparam int POS_WIDTH = u8sd_pkg::OFFSET_WIDTH;

  typedef struct packed {
    logic [20:0] value;
    logic        ok;
    logic [2:0]  nbytes;
    logic [31:0] offset;
    logic        run_end;
    logic        text_end;
  } decoded_unit_t;

  decoded_unit_t        expected_units[$];
  decoded_unit_t        want;
  logic [7:0]           held_bytes [3];
  int                   held_count;
  logic [POS_WIDTH-1:0] text_pos;

  function automatic int seq_length(input logic [7:0] lead);
    casez (lead)
      8'b0???????: return 1;
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default:     return 0;
    endcase
  endfunction

  // resolve the held bytes plus the new one into units, oldest first
  task automatic decode_request(input logic [7:0] b, input logic eot);
    logic [7:0]    window [4];
    decoded_unit_t found [4];
    logic [20:0]   cp;
    logic [63:0]   pos_wide;
    int            count;
    int            head;
    int            len;
    int            used;
    int            n;
    bit            good;
    count = held_count;
    for (int i = 0; i < count; i++) window[i] = held_bytes[i];
    window[count] = b;
    count++;
    head = 0;
    n = 0;
    while (head < count) begin
      len = seq_length(window[head]);
      // unfinished sequence keeps waiting unless the text ends here
      if (len != 0 && count - head < len && !eot) break;
      good = (len != 0) && (count - head >= len);
      cp = '0;
      if (good) begin
        case (len)
          1:       cp = {13'd0, window[head]};
          2:       cp = {16'd0, window[head][4:0]};
          3:       cp = {17'd0, window[head][3:0]};
          default: cp = {18'd0, window[head][2:0]};
        endcase
        for (int i = 1; i < len; i++) begin
          if (window[head + i][7:6] != 2'b10) good = 1'b0;
          cp = {cp[14:0], window[head + i][5:0]};
        end
        // overlong forms, surrogates, beyond the last code point
        if ((len == 2 && cp < u8sd_pkg::MIN_LEN2) || (len == 3 && cp < u8sd_pkg::MIN_LEN3) ||
            (len == 4 && cp < u8sd_pkg::MIN_LEN4)) good = 1'b0;
        if (cp >= u8sd_pkg::SURR_LO && cp <= u8sd_pkg::SURR_HI) good = 1'b0;
        if (cp > u8sd_pkg::MAX_SCALAR) good = 1'b0;
      end
      used = good ? len : 1;
      pos_wide = 64'(text_pos);
      found[n] = '{value: good ? cp : 21'd0, ok: good, nbytes: 3'(used),
                   offset: pos_wide[31:0], run_end: 1'b0, text_end: 1'b0};
      n++;
      head += used;
      text_pos += POS_WIDTH'(used);
    end
    for (int i = 0; i < n; i++) begin
      found[i].run_end  = (i == n - 1);
      found[i].text_end = (i == n - 1) && eot;
      expected_units.push_back(found[i]);
    end
    if (eot) begin
      held_count = 0;
      text_pos = '0;
    end else begin
      held_count = count - head;
      for (int i = 0; i < held_count; i++) held_bytes[i] = window[head + i];
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_units.delete();
      held_count = 0;
      text_pos = '0;
      mismatches = 0;
      units_waiting = 0;
      units_checked = 0;
      units_invalid = 0;
    end else begin
      if (in_valid && in_ready) decode_request(in_byte, end_of_text);
      if (out_valid && out_ready) begin
        if (expected_units.size() == 0) begin
          $error("unit request with none expected: value %0h at offset %0d",
                 scalar_value, start_offset);
          mismatches++;
        end else begin
          want = expected_units.pop_front();
          units_checked++;
          if (!want.ok) units_invalid++;
          if (scalar_value !== want.value) begin
            $error("scalar_value: expected %0h, got %0h", want.value, scalar_value);
            mismatches++;
          end
          if (unit_ok !== want.ok) begin
            $error("unit_ok: expected %0d, got %0d", want.ok, unit_ok);
            mismatches++;
          end
          if (unit_bytes !== want.nbytes) begin
            $error("unit_bytes: expected %0d, got %0d", want.nbytes, unit_bytes);
            mismatches++;
          end
          if (start_offset !== want.offset) begin
            $error("start_offset: expected %0d, got %0d", want.offset, start_offset);
            mismatches++;
          end
          if (run_last !== want.run_end) begin
            $error("run_last: expected %0d, got %0d", want.run_end, run_last);
            mismatches++;
          end
          if (text_last !== want.text_end) begin
            $error("text_last: expected %0d, got %0d", want.text_end, text_last);
            mismatches++;
          end
        end
      end
      units_waiting = expected_units.size();
    end
  end

endmodule

FILE: test/utf8_stream_decoder_unit_test.sv
// top of the utf-8 stream decoder test: drives byte requests and unit ready, gives the verdict
// depends on utf8_stream_decoder_unit (and u8sd_pkg) and on utf8_stream_decoder_unit_checker
module utf8_stream_decoder_unit_test;

  // long receiver hold-off, enough to back the block up into its byte input
  localparam int HOLD_OFF_CYCLES = 60;
  // cycles without any accepted request before the run is declared hung
  localparam int HANG_LIMIT      = 2000;
  // extra wait after the last expected unit, so that stray unit requests are caught
  localparam int DRAIN_CYCLES    = 12;
  localparam int RANDOM_BYTES    = 300;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        end_of_text;
  logic        out_valid;
  logic        out_ready;
  logic [20:0] scalar_value;
  logic        unit_ok;
  logic [2:0]  unit_bytes;
  logic [31:0] start_offset;
  logic        run_last;
  logic        text_last;

  int mismatches;
  int units_waiting;
  int units_checked;
  int units_invalid;

  // stimulus bookkeeping
  logic [7:0] text_bytes[$];
  int         bytes_sent;
  int         texts_sent;
  int         hold_offs_asked;
  int         hold_offs_given;
  int         stall_left;
  int         idle_edges;
  bit         quiet;   // final stretch: neither side idles
  bit         gappy;   // sender may idle while this text goes out

  utf8_stream_decoder_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .end_of_text(end_of_text),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .scalar_value(scalar_value),
    .unit_ok(unit_ok),
    .unit_bytes(unit_bytes),
    .start_offset(start_offset),
    .run_last(run_last),
    .text_last(text_last)
  );

  utf8_stream_decoder_unit_checker unit_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .end_of_text(end_of_text),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .scalar_value(scalar_value),
    .unit_ok(unit_ok),
    .unit_bytes(unit_bytes),
    .start_offset(start_offset),
    .run_last(run_last),
    .text_last(text_last),
    .mismatches(mismatches),
    .units_waiting(units_waiting),
    .units_checked(units_checked),
    .units_invalid(units_invalid)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // one byte request: optional idle burst first, then hold valid until accepted
  task automatic offer(input logic [7:0] b, input logic eot);
    int gap;
    if (!quiet && gappy && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_byte     <= b;
    end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (eot) texts_sent++;
  endtask

  // encode cp with the given length, whether or not that form is legal
  task automatic push_encoded(input logic [20:0] cp, input int len);
    case (len)
      1: text_bytes.push_back(cp[7:0]);
      2: begin
        text_bytes.push_back({3'b110, cp[10:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        text_bytes.push_back({4'b1110, cp[15:12]});
        text_bytes.push_back({2'b10, cp[11:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        text_bytes.push_back({5'b11110, cp[20:18]});
        text_bytes.push_back({2'b10, cp[17:12]});
        text_bytes.push_back({2'b10, cp[11:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // random legal code point whose shortest form has len bytes
  function automatic logic [20:0] any_scalar(input int len);
    logic [20:0] cp;
    case (len)
      1: cp = 21'($urandom_range(0, 'h7f));
      2: cp = 21'($urandom_range('h80, 'h7ff));
      3: begin
        cp = 21'($urandom_range('h800, 'hffff));
        // fold surrogates down into the plain range
        if (cp >= 'hd800 && cp <= 'hdfff) cp = cp ^ 21'h8000;
      end
      default: cp = 21'($urandom_range('h10000, 'h10ffff));
    endcase
    return cp;
  endfunction

  // mostly well-formed text, seasoned with every kind of broken sequence
  task automatic make_text();
    int          pieces;
    int          kind;
    int          len;
    int          idx;
    logic [20:0] cp;
    text_bytes.delete();
    pieces = $urandom_range(1, 10);
    repeat (pieces) begin
      kind = $urandom_range(0, 99);
      len = $urandom_range(2, 4);
      if (kind < 45) begin
        len = $urandom_range(1, 4);
        push_encoded(any_scalar(len), len);
      end else if (kind < 55) begin
        // edges of each length class and around the surrogates
        case ($urandom_range(0, 9))
          0: begin cp = 'h7f;     len = 1; end
          1: begin cp = 'h80;     len = 2; end
          2: begin cp = 'h7ff;    len = 2; end
          3: begin cp = 'h800;    len = 3; end
          4: begin cp = 'hd7ff;   len = 3; end
          5: begin cp = 'he000;   len = 3; end
          6: begin cp = 'hffff;   len = 3; end
          7: begin cp = 'h10000;  len = 4; end
          8: begin cp = 'h10ffff; len = 4; end
          default: begin cp = 'h0; len = 1; end
        endcase
        push_encoded(cp, len);
      end else if (kind < 62) begin
        // overlong form
        case (len)
          2:       cp = 21'($urandom_range(0, 'h7f));
          3:       cp = 21'($urandom_range(0, 'h7ff));
          default: cp = 21'($urandom_range(0, 'hffff));
        endcase
        push_encoded(cp, len);
      end else if (kind < 67) begin
        push_encoded(21'($urandom_range('hd800, 'hdfff)), 3);
      end else if (kind < 72) begin
        push_encoded(21'($urandom_range('h110000, 'h1fffff)), 4);
      end else if (kind < 80) begin
        // truncated sequence, next byte or end of text cuts it short
        push_encoded(any_scalar(len), len);
        repeat ($urandom_range(1, len - 1)) void'(text_bytes.pop_back());
      end else if (kind < 88) begin
        // one trailing byte replaced by anything
        push_encoded(any_scalar(len), len);
        idx = text_bytes.size() - $urandom_range(1, len - 1);
        text_bytes[idx] = 8'($urandom_range(0, 255));
      end else begin
        repeat ($urandom_range(1, 3)) text_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // unit ready: random stall bursts, long hold-offs on request, none at the end
  initial begin
    out_ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_offs_given < hold_offs_asked) begin
        hold_offs_given++;
        out_ready <= 1'b0;
        stall_left = HOLD_OFF_CYCLES - 1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 8);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: too long without any accepted request means the block hung
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_edges = 0;
    end else begin
      idle_edges++;
    end
    if (idle_edges >= HANG_LIMIT) begin
      $display("utf8_stream_decoder_unit: mismatch");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'h00;
    end_of_text = 1'b0;
    quiet = 1'b0;
    gappy = 1'b1;
    bytes_sent = 0;
    texts_sent = 0;
    hold_offs_asked = 0;
    hold_offs_given = 0;
    idle_edges = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ascii extremes, closing a one-byte-per-unit text
    offer(8'h00, 1'b0);
    offer(8'h7f, 1'b1);
    // smallest two- and three-byte values
    offer(8'hc2, 1'b0); offer(8'h80, 1'b0);
    offer(8'he0, 1'b0); offer(8'ha0, 1'b0); offer(8'h80, 1'b0);
    // encoded surrogate: lead rejected, the rest rescanned
    offer(8'hed, 1'b0); offer(8'ha0, 1'b0); offer(8'h80, 1'b0);
    // last code point ends the text
    offer(8'hf4, 1'b0); offer(8'h8f, 1'b0); offer(8'hbf, 1'b0); offer(8'hbf, 1'b1);
    // just above the last code point: four invalid units from one byte
    offer(8'hf4, 1'b0); offer(8'h90, 1'b0); offer(8'h80, 1'b0); offer(8'h80, 1'b0);
    // overlong two-byte form, then a lead followed by plain ascii
    offer(8'hc0, 1'b0); offer(8'haf, 1'b0);
    offer(8'hc3, 1'b0); offer(8'h41, 1'b0);
    // byte that can never lead, then a sequence cut off by the end of text
    offer(8'hff, 1'b0);
    offer(8'he2, 1'b0); offer(8'h82, 1'b1);

    while (bytes_sent < RANDOM_BYTES + 25) begin
      make_text();
      // long receiver hold-off while bytes keep coming
      if (texts_sent == 4 || texts_sent == 10) hold_offs_asked++;
      if (bytes_sent >= RANDOM_BYTES - 40) quiet = 1'b1;
      gappy = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < text_bytes.size(); i++) begin
        offer(text_bytes[i], i == text_bytes.size() - 1);
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // let every expected unit come out, then watch a little longer for strays
    while (units_waiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d bytes in %0d texts, with %0d long receiver hold-offs",
             bytes_sent, texts_sent, hold_offs_given);
    $display("compared %0d units, %0d of them invalid bytes", units_checked, units_invalid);
    if (mismatches == 0) begin
      $display("utf8_stream_decoder_unit: match");
    end else begin
      $display("utf8_stream_decoder_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/u8sd_pkg.sv
rtl/core/u8sd_datapath.sv
rtl/core/u8sd_ctrl.sv
rtl/core/utf8_stream_decoder_unit.sv
rtl/core/u8sd_checker.sv
test/utf8_stream_decoder_unit_checker.sv
test/utf8_stream_decoder_unit_test.sv
